### hdl/lruht_pkg.sv
// ----------------------------------------------------------------------------
// lruht_pkg
// Shared sizes, types and command/status bundles of the lru hit tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package lruht_pkg;

   // cache geometry
   localparam int WAYS        = 8;
   localparam int WAY_BITS    = $clog2(WAYS);
   localparam int BLOCK_BYTES = 64;
   localparam int OFFSET_BITS = $clog2(BLOCK_BYTES);
   localparam int ADDR_BITS   = 16;
   localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS;
   localparam int COUNT_BITS  = 16;

   // request word layout
   localparam int ADDR_IN_BITS = 18;

   // request operation codes
   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   typedef logic [WAY_BITS-1:0]   way_type;
   typedef logic [TAG_BITS-1:0]   tag_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic lookup;
      logic update;
      logic reduce;
      logic load;
   } lruht_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_free;
   } lruht_sts_type;

endpackage

`default_nettype wire

### hdl/lruht_req_if.sv
// ----------------------------------------------------------------------------
// lruht_req_if
// Request channel: one access or clear word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lruht_req_if
   import lruht_pkg::*;
   ();

   logic                    valid;
   logic                    ready;
   logic                    operation;
   logic [ADDR_IN_BITS-1:0] address;

   modport source (output valid, output operation, output address, input ready);
   modport sink   (input valid, input operation, input address, output ready);

endinterface

`default_nettype wire

### hdl/lruht_rsp_if.sv
// ----------------------------------------------------------------------------
// lruht_rsp_if
// Response channel: one lookup result word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lruht_rsp_if
   import lruht_pkg::*;
   ();

   logic      valid;
   logic      ready;
   logic      hit;
   way_type   way;
   logic      bad_address;
   count_type max_hit_count;

   modport source (output valid, output hit, output way, output bad_address,
                   output max_hit_count, input ready);
   modport sink   (input valid, input hit, input way, input bad_address,
                   input max_hit_count, output ready);

endinterface

`default_nettype wire

### hdl/lruht_ctrl.sv
// ----------------------------------------------------------------------------
// lruht_ctrl
// Sequencer: steps one request word through lookup, update, max reduction
// and response load.
// ----------------------------------------------------------------------------
`default_nettype none

module lruht_ctrl
   import lruht_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire lruht_sts_type sts,
   output lruht_cmd_type      cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOOKUP = 5'b00010,
      ST_UPDATE = 5'b00100,
      ST_REDUCE = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_REDUCE;
         ST_REDUCE: state_in = ST_FINISH;
         ST_FINISH: if (sts.rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands
   assign req_ready   = (state_ff == ST_IDLE);
   assign cmd.capture = (state_ff == ST_IDLE) && req_valid;
   assign cmd.lookup  = (state_ff == ST_LOOKUP);
   assign cmd.update  = (state_ff == ST_UPDATE);
   assign cmd.reduce  = (state_ff == ST_REDUCE);
   assign cmd.load    = (state_ff == ST_FINISH) && sts.rsp_free;

endmodule

`default_nettype wire

### hdl/lruht_dp.sv
// ----------------------------------------------------------------------------
// lruht_dp
// Datapath: line state, tag match, victim choice, age update, hit count
// maximum and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module lruht_dp
   import lruht_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lruht_cmd_type           cmd,
   output lruht_sts_type                sts,
   input  wire logic                    req_operation,
   input  wire logic [ADDR_IN_BITS-1:0] req_address,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   output logic                         rsp_hit,
   output way_type                      rsp_way,
   output logic                         rsp_bad_address,
   output count_type                    rsp_max_hit_count
);

   localparam way_type RANK_MAX = way_type'(WAYS - 1);
   localparam int      PAIRS    = WAYS / 2;

   // line state
   logic [WAYS-1:0] valid_ff;
   tag_type         tag_ff   [WAYS];
   way_type         rank_ff  [WAYS];
   count_type       count_ff [WAYS];

   // captured request word
   logic                    op_ff;
   logic [ADDR_IN_BITS-1:0] addr_ff;

   // lookup results
   logic    hit_ff;
   way_type way_ff;
   logic    bad_ff;
   logic    was_valid_ff;
   way_type old_rank_ff;

   // reduction and response registers
   count_type pair_ff [PAIRS];
   logic      rsp_valid_ff;
   logic      rsp_hit_ff;
   way_type   rsp_way_ff;
   logic      rsp_bad_ff;
   count_type rsp_max_ff;

   tag_type   blk;
   logic      bad_addr;
   logic      match_any;
   way_type   match_way;
   logic      free_any;
   way_type   free_way;
   way_type   lru_way;
   way_type   sel_way;
   count_type max_final;

   assign blk      = addr_ff[ADDR_BITS-1:OFFSET_BITS];
   assign bad_addr = (addr_ff[ADDR_IN_BITS-1:ADDR_BITS] != '0);

   // tag match, first free line and oldest line, lowest index wins
   always_comb begin
      match_any = 1'b0;
      match_way = '0;
      free_any  = 1'b0;
      free_way  = '0;
      lru_way   = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (valid_ff[i] && (tag_ff[i] == blk)) begin
            match_any = 1'b1;
            match_way = way_type'(i);
         end
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_way = way_type'(i);
         end
         if (rank_ff[i] == RANK_MAX) begin
            lru_way = way_type'(i);
         end
      end
      if (match_any) begin
         sel_way = match_way;
      end else if (free_any) begin
         sel_way = free_way;
      end else begin
         sel_way = lru_way;
      end
   end

   // input capture and lookup stage
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_operation;
         addr_ff <= req_address;
      end
      if (cmd.lookup) begin
         bad_ff       <= (op_ff == OP_ACCESS) && bad_addr;
         hit_ff       <= (op_ff == OP_ACCESS) && !bad_addr && match_any;
         way_ff       <= ((op_ff == OP_ACCESS) && !bad_addr) ? sel_way : '0;
         was_valid_ff <= match_any || !free_any;
         old_rank_ff  <= rank_ff[sel_way];
      end
   end

   // line update: clear, hit or refill
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < WAYS; i++) begin
            rank_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else if (cmd.update) begin
         if (op_ff == OP_CLEAR) begin
            valid_ff <= '0;
            for (int i = 0; i < WAYS; i++) begin
               rank_ff[i]  <= '0;
               count_ff[i] <= '0;
            end
         end else if (!bad_ff) begin
            for (int i = 0; i < WAYS; i++) begin
               if (way_ff == way_type'(i)) begin
                  rank_ff[i] <= '0;
                  if (hit_ff) begin
                     if (count_ff[i] != '1) count_ff[i] <= count_ff[i] + 1'b1;
                  end else begin
                     valid_ff[i] <= 1'b1;
                     tag_ff[i]   <= blk;
                     count_ff[i] <= '0;
                  end
               end else if (valid_ff[i] && (!was_valid_ff || rank_ff[i] < old_rank_ff)
                            && (rank_ff[i] < RANK_MAX)) begin
                  rank_ff[i] <= rank_ff[i] + 1'b1;
               end
            end
         end
      end
   end

   // first level of the max tree over valid lines
   always_ff @(posedge clock) begin
      if (cmd.reduce) begin
         for (int p = 0; p < PAIRS; p++) begin
            count_type a;
            count_type b;
            a = valid_ff[2*p]   ? count_ff[2*p]   : '0;
            b = valid_ff[2*p+1] ? count_ff[2*p+1] : '0;
            pair_ff[p] <= (a > b) ? a : b;
         end
      end
   end

   // remaining levels, folded over the pair maxima
   always_comb begin
      max_final = '0;
      for (int p = 0; p < PAIRS; p++) begin
         if (pair_ff[p] > max_final) max_final = pair_ff[p];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_hit_ff <= hit_ff;
         rsp_way_ff <= way_ff;
         rsp_bad_ff <= bad_ff;
         rsp_max_ff <= max_final;
      end
   end

   assign sts.rsp_free      = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_way           = rsp_way_ff;
   assign rsp_bad_address   = rsp_bad_ff;
   assign rsp_max_hit_count = rsp_max_ff;

endmodule

`default_nettype wire

### hdl/lru_cache_hit_tracker_core.sv
// ----------------------------------------------------------------------------
// lru_cache_hit_tracker_core
// Eight-way fully associative cache tracker with lru refill and hit counts.
// ----------------------------------------------------------------------------
// Each request word is taken when the block is idle and answered by one
// response word after the tag match and victim choice, the line and age
// update, the registered first level of the max tree over hit counts, and
// the fold of the pair maxima with the load of the response register.
// Requests are handled one at a time, so no new word is accepted until the
// last one has loaded its response;
// the response register holds a finished word while the next request works,
// and the load stalls only if that register is still full. No clearing pass
// is needed after reset.
`default_nettype none

module lru_cache_hit_tracker_core
   import lruht_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   lruht_req_if.sink   req_chan,
   lruht_rsp_if.source rsp_chan
);

   lruht_cmd_type cmd;
   lruht_sts_type sts;
   logic          req_ready;

   assign req_chan.ready = req_ready;

   // sequencer
   lruht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // line state and response
   lruht_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_chan.operation),
      .req_address       (req_chan.address),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_hit           (rsp_chan.hit),
      .rsp_way           (rsp_chan.way),
      .rsp_bad_address   (rsp_chan.bad_address),
      .rsp_max_hit_count (rsp_chan.max_hit_count)
   );

endmodule

`default_nettype wire
